@@ hw/rtl/periodic_stream_rate_scheduler_macros.svh @@
`ifndef PERIODIC_STREAM_RATE_SCHEDULER_MACROS_SVH
`define PERIODIC_STREAM_RATE_SCHEDULER_MACROS_SVH

// Same-cycle implication, checked on clk and held off during rst.
`define PSRS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk and held off during rst.
`define PSRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/psrs_pkg.sv @@
`timescale 1ns / 1ps
package psrs_pkg;

  localparam int STREAM_COUNT     = 7;
  localparam int TICKS_PER_SECOND = 1000;

  localparam int TICK_W    = 32;
  localparam int RATE_W    = 10;
  localparam int MASK_W    = 7;
  localparam int APB_DW    = 32;
  localparam int TPS_W     = $clog2(TICKS_PER_SECOND + 1);
  localparam int DIV_CNT_W = $clog2(TPS_W + 1);
  localparam int IDX_W     = (STREAM_COUNT > 1) ? $clog2(STREAM_COUNT) : 1;
  localparam int PADDR_W   = IDX_W + 2;

  localparam int STREAM_HEARTBEAT = 0;
  localparam int STREAM_PARAMS    = 6;

  typedef logic [TICK_W-1:0] tick_t;
  typedef logic [RATE_W-1:0] rate_t;
  typedef logic [TPS_W-1:0]  period_t;
  typedef logic [MASK_W-1:0] mask_t;

  localparam tick_t   NO_DEADLINE = '1;
  localparam period_t TPS_VALUE   = period_t'(TICKS_PER_SECOND);

  // Item as it walks down the row of stream cells.
  typedef struct packed {
    logic  valid;
    tick_t now;
    tick_t delay;
    mask_t mask;
    mask_t sel;
  } token_t;

  function automatic rate_t rate_reset(int idx);
    return (idx == STREAM_HEARTBEAT || idx == STREAM_PARAMS) ? rate_t'(1) : '0;
  endfunction

endpackage

@@ hw/rtl/psrs_tick_if.sv @@
`timescale 1ns / 1ps
interface psrs_tick_if;
  import psrs_pkg::*;

  logic  valid;
  logic  ready;
  tick_t now_tick;

  modport source (output valid, output now_tick, input ready);
  modport sink (input valid, input now_tick, output ready);
endinterface

@@ hw/rtl/psrs_result_if.sv @@
`timescale 1ns / 1ps
interface psrs_result_if;
  import psrs_pkg::*;

  logic  valid;
  logic  ready;
  mask_t due_mask;
  tick_t next_delay;

  modport source (output valid, output due_mask, output next_delay, input ready);
  modport sink (input valid, input due_mask, input next_delay, output ready);
endinterface

@@ hw/rtl/psrs_period_div.sv @@
`timescale 1ns / 1ps
module psrs_period_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  psrs_pkg::rate_t divisor,
  output logic            busy,
  output psrs_pkg::period_t quotient
);
  import psrs_pkg::*;

  logic [DIV_CNT_W-1:0] cnt;
  rate_t                rem;
  rate_t                dvs;
  period_t              dq;

  logic [RATE_W:0] rem_sh;
  logic            ge;
  rate_t           rem_next;

  // Restoring division of the tick base by the rate, one quotient bit a cycle.
  // Dividend bits shift out of dq at the top while quotient bits enter at the bottom.
  always_comb begin
    rem_sh   = {rem, dq[TPS_W-1]};
    ge       = rem_sh >= {1'b0, dvs};
    rem_next = ge ? RATE_W'(rem_sh - {1'b0, dvs}) : rem_sh[RATE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(TPS_W);
      rem  <= '0;
      dq   <= TPS_VALUE;
      dvs  <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      dq  <= period_t'({dq, ge});
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient = dq;

endmodule

@@ hw/rtl/psrs_cell.sv @@
`timescale 1ns / 1ps
module psrs_cell (
  input  logic             clk,
  input  logic             rst,
  input  psrs_pkg::rate_t  rst_rate,
  input  logic             wr_en,
  input  psrs_pkg::rate_t  wr_rate,
  output psrs_pkg::rate_t  rate,
  output logic             busy,
  input  psrs_pkg::token_t tok_in,
  output psrs_pkg::token_t tok_out
);
  import psrs_pkg::*;

  logic    init;
  tick_t   last;
  period_t period;
  logic    div_busy;

  tick_t  period_ext;
  tick_t  due;
  tick_t  next;
  tick_t  dt;
  logic   enabled;
  logic   hit;
  token_t tok_next;

  // The period is recomputed after reset and after every rate write.
  psrs_period_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (wr_en | init),
    .divisor  (wr_en ? wr_rate : rate),
    .busy     (div_busy),
    .quotient (period)
  );

  assign busy = init | div_busy;

  always_comb begin
    period_ext = tick_t'(period);
    due        = last + period_ext;
    next       = due + period_ext;
    enabled    = rate != '0;
    hit        = tok_in.now >= due;
    if (hit) begin
      dt = (next > tok_in.now) ? next - tok_in.now : '0;
    end else begin
      dt = due - tok_in.now;
    end

    tok_next       = tok_in;
    tok_next.delay = (enabled && dt < tok_in.delay) ? dt : tok_in.delay;
    tok_next.mask  = tok_in.mask | ((enabled && hit) ? tok_in.sel : '0);
    tok_next.sel   = tok_in.sel << 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= rst_rate;
      init <= 1'b1;
      last <= '0;
    end else begin
      init <= 1'b0;
      if (wr_en) begin
        rate <= wr_rate;
      end
      if (tok_in.valid && enabled && hit) begin
        last <= tok_in.now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

@@ hw/rtl/periodic_stream_rate_scheduler.sv @@
`timescale 1ns / 1ps
// Seven-stream periodic scheduler. Each tick transaction on ticks carries the
// current millisecond count; one result transaction on results follows with the
// mask of streams that fell due and the ticks left until the earliest next
// deadline (all ones when no stream is enabled). The tick walks a row of seven
// stream cells, one cell per cycle, then a result register and the output
// register, where the result is offered. The next tick is accepted once the
// previous result has moved into the output register. Each cell keeps its
// period as 1000 divided by its rate, made by a bit-serial divider in the cell:
// ticks is held off after a rate write and after reset while the periods are
// rebuilt. Rates are written over the APB port at byte address 4*i, stream i
// in the documented order.
`include "periodic_stream_rate_scheduler_macros.svh"
module periodic_stream_rate_scheduler (
  input  logic                          clk,
  input  logic                          rst,
  psrs_tick_if.sink                     ticks,
  psrs_result_if.source                 results,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [psrs_pkg::PADDR_W-1:0]  paddr,
  input  logic [psrs_pkg::APB_DW-1:0]   pwdata,
  output logic [psrs_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import psrs_pkg::*;

  token_t tok [STREAM_COUNT+1];
  rate_t  rates [STREAM_COUNT];
  logic [STREAM_COUNT-1:0] busy_vec;
  logic [STREAM_COUNT:0]   flight_vec;

  logic       in_flight;
  logic       accept;
  logic       apb_wr;
  logic [IDX_W-1:0] idx;
  rate_t      rd_rate;

  logic  res_v;
  mask_t res_mask;
  tick_t res_delay;
  logic  out_valid;
  mask_t out_mask;
  tick_t out_delay;
  logic  out_load;

  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite;
  assign idx    = paddr[PADDR_W-1:2];

  always_comb begin
    rd_rate = '0;
    if (int'(idx) < STREAM_COUNT) begin
      rd_rate = rates[idx];
    end
    prdata = APB_DW'(rd_rate);
  end

  assign ticks.ready = !in_flight && !res_v && !(|busy_vec);
  assign accept      = ticks.valid && ticks.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0].valid <= 1'b0;
    end else begin
      tok[0].valid <= accept;
      tok[0].now   <= ticks.now_tick;
      tok[0].delay <= NO_DEADLINE;
      tok[0].mask  <= '0;
      tok[0].sel   <= mask_t'(1);
    end
  end

  for (genvar i = 0; i < STREAM_COUNT; i++) begin : g_cell
    psrs_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .rst_rate (rate_reset(i)),
      .wr_en    (apb_wr && idx == IDX_W'(i)),
      .wr_rate  (pwdata[RATE_W-1:0]),
      .rate     (rates[i]),
      .busy     (busy_vec[i]),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= 1'b0;
    end else if (accept) begin
      in_flight <= 1'b1;
    end else if (tok[STREAM_COUNT].valid) begin
      in_flight <= 1'b0;
    end
  end

  // The result stage lets a finished item leave the row while the output
  // register still waits on the sink.
  assign out_load = res_v && (!out_valid || results.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_v <= 1'b0;
    end else if (tok[STREAM_COUNT].valid) begin
      res_v     <= 1'b1;
      res_mask  <= tok[STREAM_COUNT].mask;
      res_delay <= tok[STREAM_COUNT].delay;
    end else if (out_load) begin
      res_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
      out_mask  <= res_mask;
      out_delay <= res_delay;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign results.valid      = out_valid;
  assign results.due_mask   = out_mask;
  assign results.next_delay = out_delay;

  always_comb begin
    for (int k = 0; k <= STREAM_COUNT; k++) begin
      flight_vec[k] = tok[k].valid;
    end
  end

  `PSRS_ASSERT(a_one_item_in_row, 1'b1, $onehot0({flight_vec, res_v}), "more than one item in flight")
  `PSRS_ASSERT_NEXT(a_entry_loaded, accept, tok[0].valid && tok[0].delay == NO_DEADLINE, "accepted tick did not enter the row")
  `PSRS_ASSERT_NEXT(a_row_drains, tok[STREAM_COUNT].valid, res_v && !in_flight, "finished item not captured")

endmodule

@@ tb/tb_periodic_stream_rate_scheduler.sv @@
`timescale 1ns / 1ps
module tb_periodic_stream_rate_scheduler;
  import psrs_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int IDLE_PERCENT   = 35;

  typedef enum int {
    REG_HEARTBEAT,
    REG_SERVO_OUTPUT,
    REG_ATTITUDE,
    REG_GPS_RAW,
    REG_VFR_HUD,
    REG_GLOBAL_POSITION,
    REG_PARAMS,
    REG_PAST_END
  } rate_reg_e;

  typedef struct {
    mask_t mask;
    tick_t delay;
  } sched_t;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  psrs_tick_if   tick_ch ();
  psrs_result_if res_ch ();

  periodic_stream_rate_scheduler dut (
    .clk     (clk),
    .rst     (rst),
    .ticks   (tick_ch),
    .results (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the scheduler state.
  rate_t  rate_cfg [STREAM_COUNT];
  tick_t  last_tick [STREAM_COUNT];
  sched_t pending_schedules [$];
  sched_t want;

  int   error_count;
  int   quiet_cycles;
  int   hold_requests;
  int   hold_served;
  logic sender_gaps;
  logic recv_gaps;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic sched_t compute_schedule(input tick_t now);
    sched_t res;
    tick_t  period;
    tick_t  due_at;
    tick_t  next_at;
    res.mask  = '0;
    res.delay = '1;
    for (int s = 0; s < STREAM_COUNT; s++) begin
      if (rate_cfg[s] == '0) continue;
      period = tick_t'(TICKS_PER_SECOND) / tick_t'(rate_cfg[s]);
      due_at = last_tick[s] + period;
      if (now >= due_at) begin
        next_at      = due_at + period;
        last_tick[s] = now;
        res.mask[s]  = 1'b1;
        // A deadline that is already behind us means the stream is due again at once.
        if (next_at > now) begin
          if (next_at - now < res.delay) res.delay = next_at - now;
        end else begin
          res.delay = '0;
        end
      end else if (due_at - now < res.delay) begin
        res.delay = due_at - now;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    if (error_count < 40) $display("%0t ns: mismatch: %s", $realtime, what);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && tick_ch.valid && tick_ch.ready)
      pending_schedules.push_back(compute_schedule(tick_ch.now_tick));
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_schedules.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, mask=%h delay=%h",
                                  res_ch.due_mask, res_ch.next_delay));
      end else begin
        want = pending_schedules.pop_front();
        if (res_ch.due_mask !== want.mask)
          report_mismatch($sformatf("due_mask %h, expected %h", res_ch.due_mask, want.mask));
        if (res_ch.next_delay !== want.delay)
          report_mismatch($sformatf("next_delay %h, expected %h",
                                    res_ch.next_delay, want.delay));
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    int hold_left;
    hold_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (rst) begin
        res_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (recv_gaps) begin
        res_ch.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_tick(input tick_t now);
    while (sender_gaps && $urandom_range(0, 99) < IDLE_PERCENT) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid    <= 1'b1;
    tick_ch.now_tick <= now;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    tick_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_schedules.size() != 0) @(posedge clk);
  endtask

  task automatic write_rate(input rate_reg_e idx, input logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx < REG_PAST_END) rate_cfg[idx] = rate_t'(value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [APB_DW-1:0] pick_rate();
    case ($urandom_range(0, 9))
      0, 1:    return '0;
      2:       return 1;
      3:       return 1000;
      4:       return 1001 + $urandom_range(0, 22);
      5:       return $urandom;
      default: return $urandom_range(1, 1000);
    endcase
  endfunction

  task automatic test_reset_rates();
    send_tick(32'd0);
    send_tick(32'd999);
    send_tick(32'd1000);
    send_tick(32'd1000);
    send_tick(32'd2000);
    send_tick(32'hFFFF_FFFF);
    send_tick(32'd0);
  endtask

  task automatic test_all_disabled();
    wait_drained();
    for (int r = REG_HEARTBEAT; r <= REG_PARAMS; r++) write_rate(rate_reg_e'(r), '0);
    send_tick(32'd5);
    send_tick(32'hFFFF_FFFF);
  endtask

  task automatic test_fast_rates();
    wait_drained();
    write_rate(REG_HEARTBEAT, 1000);
    // Upper bits of the write data are dropped; 1023 leaves a zero period.
    write_rate(REG_SERVO_OUTPUT, 32'hFFFF_FFFF);
    write_rate(REG_ATTITUDE, 1001);
    write_rate(REG_GPS_RAW, 7);
    write_rate(REG_VFR_HUD, 333);
    write_rate(REG_GLOBAL_POSITION, 500);
    write_rate(REG_PARAMS, 999);
    write_rate(REG_PAST_END, 5);
    send_tick(32'd0);
    send_tick(32'd0);
    send_tick(32'd1);
    send_tick(32'd3);
    send_tick(32'hFFFF_FFFE);
    send_tick(32'hFFFF_FFFF);
    send_tick(32'd0);
  endtask

  task automatic test_due_time_wrap();
    wait_drained();
    for (int r = REG_HEARTBEAT; r <= REG_PARAMS; r++) write_rate(rate_reg_e'(r), '0);
    write_rate(REG_HEARTBEAT, 3);
    write_rate(REG_PARAMS, 1);
    send_tick(32'hFFFF_FF00);
    send_tick(32'hFFFF_FFF0);
    send_tick(32'h0000_0010);
    send_tick(32'h0000_0200);
  endtask

  task automatic test_random_streams();
    tick_t now;
    int    step_max;
    int    pick;
    now = '0;
    for (int phase = 0; phase < 12; phase++) begin
      wait_drained();
      // The first phases run without any idling on either side.
      sender_gaps = (phase >= 3);
      recv_gaps   = (phase >= 3);
      for (int r = REG_HEARTBEAT; r <= REG_PAST_END; r++) write_rate(rate_reg_e'(r), pick_rate());
      case ($urandom_range(0, 3))
        0:       now = $urandom;
        1:       now = 32'hFFFF_FFFF - $urandom_range(0, 3000);
        2:       now = $urandom_range(0, 3000);
        default: now = now + 1;
      endcase
      case ($urandom_range(0, 4))
        0:       step_max = 1;
        1:       step_max = 4;
        2:       step_max = 40;
        3:       step_max = 400;
        default: step_max = 1500;
      endcase
      for (int k = 0; k < 140; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 88)      now = now + $urandom_range(0, step_max);
        else if (pick < 95) now = now + $urandom_range(0, 5000);
        else if (pick < 98) now = $urandom;
        else                now = now - $urandom_range(1, 2000);
        send_tick(now);
      end
    end
  endtask

  task automatic test_backpressure();
    tick_t now;
    wait_drained();
    sender_gaps = 1'b0;
    for (int r = REG_HEARTBEAT; r <= REG_PARAMS; r++)
      write_rate(rate_reg_e'(r), $urandom_range(1, 1000));
    now = $urandom;
    hold_requests++;
    for (int k = 0; k < 40; k++) begin
      now = now + $urandom_range(0, 3);
      send_tick(now);
    end
    sender_gaps = 1'b1;
  endtask

  initial begin
    error_count   = 0;
    hold_requests = 0;
    hold_served   = 0;
    sender_gaps   = 1'b1;
    recv_gaps     = 1'b1;
    for (int s = 0; s < STREAM_COUNT; s++) begin
      rate_cfg[s]  = '0;
      last_tick[s] = '0;
    end
    rate_cfg[REG_HEARTBEAT] = rate_t'(1);
    rate_cfg[REG_PARAMS]    = rate_t'(1);
    rst              <= 1'b1;
    tick_ch.valid    <= 1'b0;
    tick_ch.now_tick <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_rates();
    test_all_disabled();
    test_fast_rates();
    test_due_time_wrap();
    test_backpressure();
    test_random_streams();

    wait_drained();
    repeat (30) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
